### rtl/core/sqs_pkg.sv
// Shared types and constants for the streaming quantile sketch.
// Used by sqs_err, sqs_engine and the top level; depends on nothing.
package sqs_pkg;

    localparam int MAX_TARGETS = 2;
    localparam int NUM_TARGETS = 2;
    localparam int APB_ADDR_W  = 5;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_INSERT = 2'd0;
    localparam t_mode MODE_QUERY  = 2'd1;
    localparam t_mode MODE_CLEAR  = 2'd2;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_ACTIVE = 3'd0;
    localparam t_reg_idx REG_FRAC0  = 3'd1;
    localparam t_reg_idx REG_UP0    = 3'd2;
    localparam t_reg_idx REG_LOW0   = 3'd3;
    localparam t_reg_idx REG_FRAC1  = 3'd4;
    localparam t_reg_idx REG_UP1    = 3'd5;
    localparam t_reg_idx REG_LOW1   = 3'd6;

    localparam logic [1:0]  RST_ACTIVE = 2'd1;
    localparam logic [15:0] RST_FRAC0  = 16'd32768;
    localparam logic [23:0] RST_UP0    = 24'd13107;
    localparam logic [23:0] RST_LOW0   = 24'd13107;
    localparam logic [15:0] RST_FRAC1  = 16'd58982;
    localparam logic [23:0] RST_UP1    = 24'd13107;
    localparam logic [23:0] RST_LOW1   = 24'd1456;

    typedef struct packed {
        logic [1:0]                         targets;
        logic [NUM_TARGETS-1:0][15:0]       frac;
        logic [NUM_TARGETS-1:0][23:0]       up;
        logic [NUM_TARGETS-1:0][23:0]       low;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] value;
        logic [31:0]        weight;
        logic [31:0]        delta;
    } t_entry;

    typedef struct packed {
        t_mode              mode;
        logic signed [31:0] sample;
        logic [15:0]        qfrac;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] qvalue;
        logic               qvalid;
        logic               full;
    } t_result;

endpackage

### rtl/core/sqs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

### rtl/core/sqs_err.sv
// Error-bound pipeline: err(rank) in Q.16 for a table of len entries.
// Depends on sqs_pkg.
module sqs_err import sqs_pkg::*; #(
    parameter int LEN_W = 11,
    parameter int ERR_W = LEN_W + 17
) (
    input  logic             i_clk,
    input  t_cfg             i_cfg,
    input  logic [31:0]      i_rank,
    input  logic [LEN_W-1:0] i_len,
    output logic [ERR_W-1:0] o_err
);

    logic [NUM_TARGETS-1:0]       r_lower;
    logic [31:0]                  r_rank;
    logic [31:0]                  r_diff;
    logic [LEN_W-1:0]             r_len;
    logic                         r_use1;
    logic [NUM_TARGETS-1:0][55:0] r_prod;
    logic [ERR_W-1:0]             r_best;
    logic                         r_use1_d;
    logic [55:0]                  best_c;
    logic [47:0]                  lhs;

    assign lhs = {i_rank, 16'd0};

    always_ff @(posedge i_clk) begin
        for (int t = 0; t < NUM_TARGETS; t++) begin
            r_lower[t] <= lhs > (48'(i_cfg.frac[t]) * 48'(i_len));
        end
        r_rank <= i_rank;
        r_diff <= 32'(i_len) - i_rank;
        r_len  <= i_len;
        r_use1 <= (MAX_TARGETS > 1) && i_cfg.targets[1];

        for (int t = 0; t < NUM_TARGETS; t++) begin
            r_prod[t] <= r_lower[t] ? 56'(i_cfg.low[t]) * 56'(r_rank)
                                    : 56'(i_cfg.up[t]) * 56'(r_diff);
        end
        r_best   <= {(LEN_W+1)'(r_len) + (LEN_W+1)'(1), 16'd0};
        r_use1_d <= r_use1;

        o_err <= ERR_W'(best_c);
    end

    always_comb begin
        best_c = 56'(r_best);
        if (r_prod[0] < best_c) begin
            best_c = r_prod[0];
        end
        if (r_use1_d && r_prod[1] < best_c) begin
            best_c = r_prod[1];
        end
    end

endmodule

### rtl/core/sqs_engine.sv
// Sequencer for insert, clear, sort, merge, compress and query over the batch and table RAMs.
// Depends on sqs_pkg, sqs_ram and sqs_err.
module sqs_engine import sqs_pkg::*; #(
    parameter int BATCH_SIZE    = 512,
    parameter int SUMMARY_DEPTH = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_start,
    input  t_cmd    i_cmd,
    output logic    o_ready,
    output logic    o_done,
    output t_result o_result
);

    localparam int LEN_W   = $clog2(SUMMARY_DEPTH + 1);
    localparam int TA_W    = $clog2(SUMMARY_DEPTH);
    localparam int FILL_W  = $clog2(BATCH_SIZE + 1);
    localparam int BA_W    = $clog2(BATCH_SIZE);
    localparam int ERR_W   = LEN_W + 17;
    localparam int SUM_W   = LEN_W + FILL_W;
    localparam int RANK_W  = 32 + LEN_W;
    localparam int BOUND_W = 50;
    localparam int QCMP_W  = RANK_W + 18;
    localparam int ENT_W   = $bits(t_entry);

    typedef enum logic [4:0] {
        S_IDLE, S_INS_CHK,
        S_SORT_RDX, S_SORT_X, S_SORT_CHK, S_SORT_CMP,
        S_MRG_RDX, S_MRG_X, S_MRG_CHK, S_MRG_CMP, S_MRG_WR,
        S_CMP_INIT, S_CMP_K0, S_CMP_RD, S_CMP_CAP, S_CMP_DEC, S_CMP_END,
        S_Q_START, S_Q_ERR, S_Q_BND, S_Q_P0, S_Q_RD, S_Q_CMP,
        S_WAIT, S_DONE
    } t_state;

    t_state               r_state;
    t_state               r_ret;
    t_state               r_after;
    logic [1:0]           r_cnt;
    logic [LEN_W-1:0]     r_slen;
    logic [FILL_W-1:0]    r_bfill;
    logic [31:0]          r_total;
    t_cmd                 r_cmd;
    logic [FILL_W-1:0]    r_i;
    logic [FILL_W-1:0]    r_j;
    logic signed [31:0]   r_x;
    logic [LEN_W-1:0]     r_k;
    logic [LEN_W-1:0]     r_w;
    logic [LEN_W-1:0]     r_r;
    t_entry               r_kept;
    t_entry               r_cand;
    logic [31:0]          r_err_rank;
    logic [LEN_W-1:0]     r_err_len;
    logic [31:0]          r_desired;
    logic [BOUND_W-1:0]   r_bound;
    logic [RANK_W-1:0]    r_rank;
    t_result              r_res;

    logic                 b_we;
    logic [BA_W-1:0]      b_waddr;
    logic [31:0]          b_wdata;
    logic [BA_W-1:0]      b_raddr;
    logic signed [31:0]   b_rdata;
    logic                 t_we;
    logic [TA_W-1:0]      t_waddr;
    t_entry               t_wdata;
    logic [TA_W-1:0]      t_raddr;
    t_entry               t_rdata;
    logic [ENT_W-1:0]     t_rdata_raw;
    logic [ERR_W-1:0]     err;

    logic [SUM_W-1:0]     fill_sum;
    logic                 fill_reached;
    logic                 merge_more;
    logic [31:0]          mrg_delta;
    logic [33:0]          cmp_sum;
    logic                 cmp_join;
    logic [32:0]          join_w;
    logic [RANK_W:0]      q_sum;
    logic                 q_stop;
    logic [47:0]          q_prod;

    assign t_rdata = t_entry'(t_rdata_raw);

    sqs_ram #(.WIDTH(32), .DEPTH(BATCH_SIZE)) u_batch_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    sqs_ram #(.WIDTH(ENT_W), .DEPTH(SUMMARY_DEPTH)) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata_raw)
    );

    sqs_err #(.LEN_W(LEN_W), .ERR_W(ERR_W)) u_err (
        .i_clk  (i_clk),
        .i_cfg  (i_cfg),
        .i_rank (r_err_rank),
        .i_len  (r_err_len),
        .o_err  (err)
    );

    assign fill_sum     = SUM_W'(r_slen) + SUM_W'(r_bfill);
    assign fill_reached = fill_sum >= SUM_W'(SUMMARY_DEPTH);
    assign merge_more   = (r_i < r_bfill) && (r_slen < LEN_W'(SUMMARY_DEPTH));
    assign mrg_delta    = (r_k != '0 && r_k < r_slen) ? (32'(err >> 16) + 32'd1) : 32'd0;
    assign cmp_sum      = 34'(r_kept.weight) + 34'(r_cand.weight) + 34'(r_cand.delta);
    assign cmp_join     = {cmp_sum, 16'd0} <= 50'(err);
    assign join_w       = 33'(r_kept.weight) + 33'(r_cand.weight);
    assign q_sum        = (RANK_W+1)'(r_rank) + (RANK_W+1)'(t_rdata.weight)
                        + (RANK_W+1)'(t_rdata.delta);
    assign q_stop       = {q_sum, 17'd0} > QCMP_W'(r_bound);
    assign q_prod       = 48'(r_cmd.qfrac) * 48'(r_total);

    assign o_ready  = (r_state == S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign o_result = r_res;

    always_comb begin
        b_we    = 1'b0;
        b_waddr = '0;
        b_wdata = '0;
        b_raddr = '0;
        t_we    = 1'b0;
        t_waddr = '0;
        t_wdata = '0;
        t_raddr = '0;
        unique case (r_state)
            S_INS_CHK: begin
                b_we    = !(r_slen >= LEN_W'(SUMMARY_DEPTH) || fill_reached);
                b_waddr = r_bfill[BA_W-1:0];
                b_wdata = r_cmd.sample;
            end
            S_SORT_RDX: b_raddr = r_i[BA_W-1:0];
            S_SORT_CHK: begin
                if (r_j == '0) begin
                    b_we    = 1'b1;
                    b_wdata = r_x;
                end else begin
                    b_raddr = BA_W'(r_j - 1'b1);
                end
            end
            S_SORT_CMP: begin
                b_we    = 1'b1;
                b_waddr = r_j[BA_W-1:0];
                b_wdata = (b_rdata > r_x) ? b_rdata : r_x;
            end
            S_MRG_RDX: b_raddr = r_i[BA_W-1:0];
            S_MRG_CHK: t_raddr = TA_W'(r_k - 1'b1);
            S_MRG_CMP: begin
                t_we    = t_rdata.value >= r_x;
                t_waddr = r_k[TA_W-1:0];
                t_wdata = t_rdata;
            end
            S_MRG_WR: begin
                t_we    = 1'b1;
                t_waddr = r_k[TA_W-1:0];
                t_wdata = '{value: r_x, weight: 32'd1, delta: mrg_delta};
            end
            S_CMP_INIT: t_raddr = '0;
            S_CMP_RD:   t_raddr = r_r[TA_W-1:0];
            S_CMP_DEC: begin
                t_we    = !cmp_join;
                t_waddr = r_w[TA_W-1:0];
                t_wdata = r_kept;
            end
            S_CMP_END: begin
                t_we    = 1'b1;
                t_waddr = r_w[TA_W-1:0];
                t_wdata = r_kept;
            end
            S_Q_BND: t_raddr = '0;
            S_Q_RD:  t_raddr = r_r[TA_W-1:0];
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slen  <= '0;
            r_bfill <= '0;
            r_total <= '0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cmd <= i_cmd;
                        r_res <= '0;
                        r_i   <= FILL_W'(1);
                        unique case (i_cmd.mode)
                            MODE_INSERT: begin
                                r_after <= S_INS_CHK;
                                r_state <= (fill_reached && r_bfill != '0) ? S_SORT_RDX
                                                                           : S_INS_CHK;
                            end
                            MODE_QUERY: begin
                                r_after <= S_Q_START;
                                r_state <= S_SORT_RDX;
                            end
                            MODE_CLEAR: begin
                                r_slen  <= '0;
                                r_bfill <= '0;
                                r_total <= '0;
                                r_state <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_INS_CHK: begin
                    if (r_slen >= LEN_W'(SUMMARY_DEPTH) || fill_reached) begin
                        r_res.full <= 1'b1;
                        r_state    <= S_DONE;
                    end else begin
                        r_bfill <= r_bfill + 1'b1;
                        r_i     <= FILL_W'(1);
                        r_after <= S_DONE;
                        r_state <= (r_bfill == FILL_W'(BATCH_SIZE - 1)) ? S_SORT_RDX : S_DONE;
                    end
                end
                S_SORT_RDX: begin
                    if (r_i >= r_bfill) begin
                        r_i     <= '0;
                        r_state <= S_MRG_RDX;
                    end else begin
                        r_state <= S_SORT_X;
                    end
                end
                S_SORT_X: begin
                    r_x     <= b_rdata;
                    r_j     <= r_i;
                    r_state <= S_SORT_CHK;
                end
                S_SORT_CHK: begin
                    if (r_j == '0) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SORT_RDX;
                    end else begin
                        r_state <= S_SORT_CMP;
                    end
                end
                S_SORT_CMP: begin
                    if (b_rdata > r_x) begin
                        r_j     <= r_j - 1'b1;
                        r_state <= S_SORT_CHK;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SORT_RDX;
                    end
                end
                S_MRG_RDX: begin
                    if (merge_more) begin
                        r_state <= S_MRG_X;
                    end else begin
                        r_bfill <= '0;
                        r_state <= S_CMP_INIT;
                    end
                end
                S_MRG_X: begin
                    r_x     <= b_rdata;
                    r_k     <= r_slen;
                    r_state <= S_MRG_CHK;
                end
                S_MRG_CHK: begin
                    if (r_k == '0) begin
                        r_err_rank <= 32'd1;
                        r_err_len  <= r_slen;
                        r_ret      <= S_MRG_WR;
                        r_cnt      <= '0;
                        r_state    <= S_WAIT;
                    end else begin
                        r_state <= S_MRG_CMP;
                    end
                end
                S_MRG_CMP: begin
                    if (t_rdata.value >= r_x) begin
                        r_k     <= r_k - 1'b1;
                        r_state <= S_MRG_CHK;
                    end else begin
                        r_err_rank <= 32'(r_k) + 32'd1;
                        r_err_len  <= r_slen;
                        r_ret      <= S_MRG_WR;
                        r_cnt      <= '0;
                        r_state    <= S_WAIT;
                    end
                end
                S_MRG_WR: begin
                    r_slen  <= r_slen + 1'b1;
                    r_total <= (r_total == '1) ? r_total : r_total + 32'd1;
                    r_i     <= r_i + 1'b1;
                    r_state <= S_MRG_RDX;
                end
                S_CMP_INIT: begin
                    r_state <= (r_slen < LEN_W'(2)) ? r_after : S_CMP_K0;
                end
                S_CMP_K0: begin
                    r_kept  <= t_rdata;
                    r_w     <= '0;
                    r_r     <= LEN_W'(1);
                    r_state <= S_CMP_RD;
                end
                S_CMP_RD: begin
                    r_err_rank <= 32'(r_w);
                    r_err_len  <= r_slen;
                    r_state    <= S_CMP_CAP;
                end
                S_CMP_CAP: begin
                    r_cand  <= t_rdata;
                    r_ret   <= S_CMP_DEC;
                    r_cnt   <= '0;
                    r_state <= S_WAIT;
                end
                S_CMP_DEC: begin
                    if (cmp_join) begin
                        r_kept.weight <= join_w[32] ? '1 : join_w[31:0];
                    end else begin
                        r_w    <= r_w + 1'b1;
                        r_kept <= r_cand;
                    end
                    r_r     <= r_r + 1'b1;
                    r_state <= (r_r + 1'b1 == r_slen) ? S_CMP_END : S_CMP_RD;
                end
                S_CMP_END: begin
                    r_slen  <= r_w + 1'b1;
                    r_state <= r_after;
                end
                S_Q_START: begin
                    r_desired <= q_prod[47:16];
                    r_state   <= (r_slen == '0) ? S_DONE : S_Q_ERR;
                end
                S_Q_ERR: begin
                    r_err_rank <= r_desired;
                    r_err_len  <= r_slen;
                    r_ret      <= S_Q_BND;
                    r_cnt      <= '0;
                    r_state    <= S_WAIT;
                end
                S_Q_BND: begin
                    r_bound <= BOUND_W'({r_desired, 17'd0}) + BOUND_W'(err);
                    r_state <= S_Q_P0;
                end
                S_Q_P0: begin
                    r_kept  <= t_rdata;
                    r_rank  <= '0;
                    r_r     <= LEN_W'(1);
                    r_state <= S_Q_RD;
                end
                S_Q_RD: begin
                    if (r_r == r_slen) begin
                        r_res.qvalue <= r_kept.value;
                        r_res.qvalid <= 1'b1;
                        r_state      <= S_DONE;
                    end else begin
                        r_rank  <= r_rank + RANK_W'(r_kept.weight);
                        r_state <= S_Q_CMP;
                    end
                end
                S_Q_CMP: begin
                    if (q_stop) begin
                        r_res.qvalue <= r_kept.value;
                        r_res.qvalid <= 1'b1;
                        r_state      <= S_DONE;
                    end else begin
                        r_kept  <= t_rdata;
                        r_r     <= r_r + 1'b1;
                        r_state <= S_Q_RD;
                    end
                end
                S_WAIT: begin
                    if (r_cnt == 2'd3) begin
                        r_state <= r_ret;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/streaming_quantile_sketch.sv
// Top level of the streaming quantile sketch: APB register file, stream ports, result register.
// Depends on sqs_pkg and sqs_engine.
//
// Each transaction on the input stream produces exactly one result transaction. Every
// BATCH_SIZE-th insert, an insert that finds table plus batch at SUMMARY_DEPTH, and every
// query also flush the batch: an insertion sort of the batch, a merge that walks the table
// from the top for each sample, and a compress pass over the table entries. A query then
// walks the table. These passes are paced by the single read port of the table and batch
// memories and by the 3-stage error-bound pipeline. No clearing pass is needed after reset.
module streaming_quantile_sketch import sqs_pkg::*; #(
    parameter int BATCH_SIZE    = 512,
    parameter int SUMMARY_DEPTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [47:0]           i_s_tdata,   // [31:0] sample_value, [47:32] query_fraction
    input  logic [1:0]            i_s_tuser,   // [1:0] mode
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [31:0]           o_m_tdata,   // [31:0] quantile_value
    output logic [1:0]            o_m_tuser,   // [0] quantile_valid, [1] table_full
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_cfg       r_cfg;
    logic       r_mvalid;
    logic [31:0] r_mdata;
    logic [1:0] r_muser;
    logic       eng_ready;
    logic       eng_done;
    t_result    eng_res;
    t_cmd       cmd;
    logic       accept;
    t_reg_idx   reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.targets <= RST_ACTIVE;
            r_cfg.frac[0] <= RST_FRAC0;
            r_cfg.up[0]   <= RST_UP0;
            r_cfg.low[0]  <= RST_LOW0;
            r_cfg.frac[1] <= RST_FRAC1;
            r_cfg.up[1]   <= RST_UP1;
            r_cfg.low[1]  <= RST_LOW1;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_ACTIVE: r_cfg.targets <= pwdata[1:0];
                REG_FRAC0:  r_cfg.frac[0] <= pwdata[15:0];
                REG_UP0:    r_cfg.up[0]   <= pwdata[23:0];
                REG_LOW0:   r_cfg.low[0]  <= pwdata[23:0];
                REG_FRAC1:  r_cfg.frac[1] <= pwdata[15:0];
                REG_UP1:    r_cfg.up[1]   <= pwdata[23:0];
                REG_LOW1:   r_cfg.low[1]  <= pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ACTIVE: prdata = 32'(r_cfg.targets);
            REG_FRAC0:  prdata = 32'(r_cfg.frac[0]);
            REG_UP0:    prdata = 32'(r_cfg.up[0]);
            REG_LOW0:   prdata = 32'(r_cfg.low[0]);
            REG_FRAC1:  prdata = 32'(r_cfg.frac[1]);
            REG_UP1:    prdata = 32'(r_cfg.up[1]);
            REG_LOW1:   prdata = 32'(r_cfg.low[1]);
            default:    prdata = '0;
        endcase
    end

    assign o_s_tready = eng_ready && (!r_mvalid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;
    assign cmd.mode   = i_s_tuser;
    assign cmd.sample = $signed(i_s_tdata[31:0]);
    assign cmd.qfrac  = i_s_tdata[47:32];

    sqs_engine #(
        .BATCH_SIZE    (BATCH_SIZE),
        .SUMMARY_DEPTH (SUMMARY_DEPTH)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_start  (accept),
        .i_cmd    (cmd),
        .o_ready  (eng_ready),
        .o_done   (eng_done),
        .o_result (eng_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else begin
            if (eng_done) begin
                r_mvalid <= 1'b1;
                r_mdata  <= eng_res.qvalue;
                r_muser  <= {eng_res.full, eng_res.qvalid};
            end else if (i_m_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_mvalid;
    assign o_m_tdata  = r_mdata;
    assign o_m_tuser  = r_muser;

endmodule

### rtl/core/sqs_checker.sv
// Port-level checker for the streaming quantile sketch, bound to the top level.
// Depends on streaming_quantile_sketch ports only.
module sqs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result transaction dropped while stalled");

    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("answered query and dropped insert in one result");

    a_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata == 32'd0)
        else $error("value nonzero without a valid answer");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken again before the transaction finished");

endmodule

bind streaming_quantile_sketch sqs_checker u_sqs_checker (.*);
